### design/ocf_pkg.sv
// Shared types, constants and frame layout of the overlay command framer.
package ocf_pkg;

	localparam logic [1:0] OP_SWITCH = 2'd0;
	localparam logic [1:0] OP_MILE   = 2'd1;
	localparam logic [1:0] OP_COORD  = 2'd2;

	localparam logic [4:0] MILE_LEN   = 5'd11;
	localparam logic [4:0] COORD_LEN  = 5'd22;
	localparam logic [4:0] MILE_DOT_POS = 5'd4;
	localparam logic [4:0] FIELD_LEN  = 5'd11;
	localparam logic [4:0] DEG_POS    = 5'd3;
	localparam logic [4:0] MIN_POS    = 5'd6;
	localparam logic [4:0] SEC_POS    = 5'd9;
	localparam logic [4:0] COORD_FRAME_LEN = 5'd27;

	localparam logic [7:0] HDR_BYTE   = 8'h05;
	localparam logic [7:0] TERM_BYTE  = 8'h17;
	localparam logic [7:0] ON_BYTE    = 8'hAA;
	localparam logic [7:0] OFF_BYTE   = 8'h00;
	localparam logic [7:0] DEG_BYTE   = 8'hA7;
	localparam logic [7:0] APOS_BYTE  = 8'h27;
	localparam logic [7:0] QUOTE_BYTE = 8'h22;
	localparam logic [7:0] DOT_BYTE   = 8'h2E;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] K_BYTE     = 8'h4B;
	localparam logic [7:0] M_BYTE     = 8'h6D;
	localparam logic [7:0] SLASH_BYTE = 8'h2F;
	localparam logic [7:0] H_BYTE     = 8'h68;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] MILE_ID    = 8'h01;
	localparam logic [7:0] COORD_ID   = 8'h02;
	localparam logic [7:0] INDEX_OFS  = 8'h02;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_PUT
	} fsm_t;

	typedef enum logic [1:0] {
		FRM_SWITCH,
		FRM_MILE,
		FRM_COORD,
		FRM_ERROR
	} frame_t;

	typedef enum logic [2:0] {
		SRC_CONST,
		SRC_STORE,
		SRC_SUM,
		SRC_INDEX,
		SRC_FLAG
	} src_t;

	typedef struct packed {
		src_t       src;
		logic [7:0] value;
		logic [4:0] addr;
		logic       body;
		logic       last;
		logic       err;
	} slot_t;

	typedef struct packed {
		logic done;
		logic ok;
		logic coord;
	} intake_t;

	function automatic logic [7:0] to_ascii(logic [7:0] v);
		return (v <= 8'd9) ? v + ZERO_CHAR : v;
	endfunction

	function automatic slot_t frame_slot(frame_t f, logic [4:0] pos);
		slot_t s;
		s.src   = SRC_CONST;
		s.value = OFF_BYTE;
		s.addr  = '0;
		s.body  = 1'b1;
		s.last  = 1'b0;
		s.err   = 1'b0;
		unique case (f)
			FRM_SWITCH: begin
				unique case (pos)
					5'd0: begin
						s.value = HDR_BYTE;
						s.body  = 1'b0;
					end
					5'd1: s.src = SRC_INDEX;
					5'd2: s.src = SRC_FLAG;
					5'd3: begin
						s.src  = SRC_SUM;
						s.body = 1'b0;
					end
					default: begin
						s.value = TERM_BYTE;
						s.body  = 1'b0;
						s.last  = 1'b1;
					end
				endcase
			end
			FRM_MILE: begin
				priority if (pos == 5'd0) begin
					s.value = HDR_BYTE;
					s.body  = 1'b0;
				end else if (pos == 5'd1) begin
					s.value = MILE_ID;
				end else if (pos <= 5'd9) begin
					s.src  = SRC_STORE;
					s.addr = pos - 5'd2;
				end else if (pos >= 5'd13 && pos <= 5'd15) begin
					s.src  = SRC_STORE;
					s.addr = pos - 5'd5;
				end else if (pos == 5'd20) begin
					s.src  = SRC_SUM;
					s.body = 1'b0;
				end else if (pos >= 5'd21) begin
					s.value = TERM_BYTE;
					s.body  = 1'b0;
					s.last  = 1'b1;
				end else begin
					unique case (pos)
						5'd10, 5'd16: s.value = K_BYTE;
						5'd11, 5'd17: s.value = M_BYTE;
						5'd12:        s.value = SPACE_BYTE;
						5'd18:        s.value = SLASH_BYTE;
						default:      s.value = H_BYTE;
					endcase
				end
			end
			FRM_COORD: begin
				priority if (pos == 5'd0) begin
					s.value = HDR_BYTE;
					s.body  = 1'b0;
				end else if (pos == 5'd1) begin
					s.value = COORD_ID;
				end else if (pos <= 5'd12) begin
					s.src  = SRC_STORE;
					s.addr = pos - 5'd2;
				end else if (pos == 5'd13) begin
					s.value = SPACE_BYTE;
				end else if (pos <= 5'd24) begin
					s.src  = SRC_STORE;
					s.addr = pos - 5'd3;
				end else if (pos == 5'd25) begin
					s.src  = SRC_SUM;
					s.body = 1'b0;
				end else begin
					s.value = TERM_BYTE;
					s.body  = 1'b0;
					s.last  = 1'b1;
				end
			end
			default: begin
				s.body = 1'b0;
				s.last = 1'b1;
				s.err  = 1'b1;
			end
		endcase
		return s;
	endfunction

endpackage

### design/ocf_if.sv
// Request channels of the overlay command framer: commands in, frame bytes out.
interface ocf_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic [7:0] entry_index;
	logic       switch_on;

	modport source (output valid, opcode, data_byte, entry_index, switch_on, input ready);
	modport sink (input valid, opcode, data_byte, entry_index, switch_on, output ready);
endinterface

interface ocf_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_last;
	logic       format_error;

	modport source (output valid, out_byte, frame_last, format_error, input ready);
	modport sink (input valid, out_byte, frame_last, format_error, output ready);
endinterface

### design/ocf_payload_store.sv
// Payload store with byte count, message kind and separator checks.
module ocf_payload_store import ocf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_op,
	input  logic [7:0] wr_data,
	input  logic [4:0] rd_addr,
	output logic [7:0] rd_data,
	output intake_t    status
);

	logic [7:0] mem [COORD_LEN];
	logic [7:0] rd_data_q;
	logic [4:0] count_q;
	logic [1:0] kind_q;
	logic       ok_q;

	logic [4:0] need;
	logic       fresh;
	logic [4:0] wa;
	logic [4:0] cnt_new;
	logic       ok_prev;
	logic       sep_ok;
	logic       coord;

	always_comb begin
		coord   = (wr_op == OP_COORD);
		need    = coord ? COORD_LEN : MILE_LEN;
		fresh   = (kind_q != wr_op) || (count_q >= need);
		wa      = fresh ? 5'd0 : count_q;
		ok_prev = fresh ? 1'b1 : ok_q;
		cnt_new = wa + 5'd1;
		sep_ok  = 1'b1;
		if (coord) begin
			priority if (wa == DEG_POS || wa == DEG_POS + FIELD_LEN) begin
				sep_ok = (wr_data == DEG_BYTE);
			end else if (wa == MIN_POS || wa == MIN_POS + FIELD_LEN) begin
				sep_ok = (wr_data == APOS_BYTE);
			end else if (wa == SEC_POS || wa == SEC_POS + FIELD_LEN) begin
				sep_ok = (wr_data == QUOTE_BYTE);
			end else begin
				sep_ok = 1'b1;
			end
		end else if (wa == MILE_DOT_POS) begin
			sep_ok = (wr_data == DOT_BYTE);
		end
		status.done  = (cnt_new == need);
		status.ok    = ok_prev && sep_ok;
		status.coord = coord;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			kind_q  <= OP_SWITCH;
			ok_q    <= 1'b1;
		end else if (wr_en) begin
			count_q <= status.done ? 5'd0 : cnt_new;
			kind_q  <= wr_op;
			ok_q    <= status.done ? 1'b1 : status.ok;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### design/overlay_command_framer.sv
// Top level of the overlay command framer: intake, frame sequencer, output register.
//
// cmd channel takes one request per cycle while the sequencer is idle. A switch
// request (opcode 0) starts a five-byte frame at once. Payload requests
// (opcodes 1 and 2) are written to the payload store; the eleventh mileage byte
// or the twenty-second coordinate byte starts the frame, or a single error
// byte when a separator is wrong. Opcode 3 is taken and ignored.
// frame channel delivers one byte per request, frame_last on the terminator.
// After the starting request each byte passes through ST_FETCH (store read),
// then ST_PUT (output load); the next byte is fetched only after the last one
// is loaded. The registered read of the payload store sets that pace.
// cmd.ready is low while a frame is being built. When the receiver stalls the
// output register holds its byte and the sequencer waits; payload requests are
// still taken once the last byte of a frame sits in the output register.
// Reset clears count, message kind, sequencer and output valid; store
// contents are not cleared and need no clearing pass.
module overlay_command_framer import ocf_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	ocf_cmd_if.sink     cmd,
	ocf_frame_if.source frame
);

	fsm_t       state_q, state_d;
	frame_t     frame_q;
	logic [4:0] pos_q;
	logic [7:0] idx_q;
	logic       on_q;
	logic [7:0] sum_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       olast_q;
	logic       oerr_q;

	logic       accept;
	logic       payload;
	logic       start;
	logic       slot_free;
	logic       load;
	logic       ready_c;
	logic [7:0] rd_data;
	logic [7:0] byte_c;
	intake_t    status;
	slot_t      slot;

	assign accept  = cmd.valid && ready_c;
	assign payload = (cmd.opcode == OP_MILE) || (cmd.opcode == OP_COORD);
	assign start   = (cmd.opcode == OP_SWITCH) || (payload && status.done);
	assign slot    = frame_slot(frame_q, pos_q);

	ocf_payload_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && payload),
		.wr_op   (cmd.opcode),
		.wr_data (cmd.data_byte),
		.rd_addr (slot.addr),
		.rd_data (rd_data),
		.status  (status)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && start) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_PUT;
			ST_PUT:   if (slot_free) state_d = slot.last ? ST_IDLE : ST_FETCH;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready_c   = (state_q == ST_IDLE);
		slot_free = !ovalid_q || frame.ready;
		load      = (state_q == ST_PUT) && slot_free;
		unique case (slot.src)
			SRC_STORE: byte_c = to_ascii(rd_data);
			SRC_SUM:   byte_c = sum_q;
			SRC_INDEX: byte_c = idx_q + INDEX_OFS;
			SRC_FLAG:  byte_c = on_q ? ON_BYTE : OFF_BYTE;
			default:   byte_c = slot.value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (frame.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && start) begin
			pos_q <= '0;
			sum_q <= '0;
			if (cmd.opcode == OP_SWITCH) begin
				frame_q <= FRM_SWITCH;
				idx_q   <= cmd.entry_index;
				on_q    <= cmd.switch_on;
			end else if (!status.ok) begin
				frame_q <= FRM_ERROR;
			end else begin
				frame_q <= status.coord ? FRM_COORD : FRM_MILE;
			end
		end else if (load) begin
			pos_q <= pos_q + 5'd1;
			if (slot.body) begin
				sum_q <= sum_q + byte_c;
			end
		end
		if (load) begin
			obyte_q <= byte_c;
			olast_q <= slot.last;
			oerr_q  <= slot.err;
		end
	end

	assign cmd.ready          = ready_c;
	assign frame.valid        = ovalid_q;
	assign frame.out_byte     = obyte_q;
	assign frame.frame_last   = olast_q;
	assign frame.format_error = oerr_q;

`ifndef SYNTH
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && oerr_q |-> olast_q && obyte_q == OFF_BYTE)
		else $error("error result without frame_last");

	a_switch_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.opcode == OP_SWITCH
		|=> state_q == ST_FETCH && frame_q == FRM_SWITCH)
		else $error("switch request did not start a frame");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> pos_q < COORD_FRAME_LEN)
		else $error("frame position out of range");
`endif

endmodule
